// File: rtl/lrps_pkg.sv
// lrps_pkg: shared types, codes and constants of the relay pulse sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package lrps_pkg;

    localparam int NUM_COILS      = 66;
    localparam int COIL_WORD_W    = 33;
    localparam int TICK_W         = 16;
    localparam int RELAY_W        = 5;
    localparam int COIL_NUM_W     = 7;
    localparam int CFG_INDEX_W    = 2;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 80;

    localparam logic [RELAY_W-1:0]    HOST_RELAY   = 5'd10;
    localparam logic [RELAY_W-1:0]    NUM_SINGLE   = 5'd13;
    localparam logic [RELAY_W-1:0]    NUM_RELAYS   = 5'd23;
    localparam logic [COIL_NUM_W-1:0] DUAL_BASE    = 7'd26;
    localparam int                    HOST_SET_COIL = 20;
    localparam int                    HOST_RST_COIL = 21;
    localparam logic [TICK_W-1:0]     TICK_MAX     = 16'hffff;

    localparam logic [TICK_W-1:0] PULSE_TICKS_RST  = 16'd30;
    localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 16'd100;
    localparam logic [TICK_W-1:0] STEP_TICKS_RST   = 16'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TICKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TICKS   = 2'd2;

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [2:0] {
        SEQ_IDLE         = 3'd0,
        SEQ_ON_PULSE     = 3'd1,
        SEQ_SETTLE       = 3'd2,
        SEQ_AFTER_STOP   = 3'd3,
        SEQ_AFTER_DEINIT = 3'd4,
        SEQ_OFF_PULSE    = 3'd5
    } seq_step_t;

    typedef struct packed {
        logic [TICK_W-1:0] pulse_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] step_ticks;
    } lrps_cfg_t;

    typedef struct packed {
        logic               op;
        logic [RELAY_W-1:0] relay_index;
        logic               channel;
        logic               turn_on;
    } lrps_item_t;

    typedef struct packed {
        logic [NUM_COILS-1:0] coils;
        logic [TICK_W-1:0]    pulse_timer;
        logic                 driver_on;
        seq_step_t            step;
        logic [TICK_W-1:0]    elapsed;
    } lrps_state_t;

    typedef struct packed {
        logic [COIL_WORD_W-1:0] coils_low;
        logic [COIL_WORD_W-1:0] coils_high;
        logic                   driver_enable;
        logic                   host_stop_req;
        logic                   host_deinit_req;
        logic                   host_init_req;
        logic                   report_valid;
        logic [RELAY_W-1:0]     report_relay;
        logic                   report_on;
        logic                   sequence_busy;
    } lrps_result_t;

endpackage

`default_nettype wire

// File: rtl/lrps_step.sv
// lrps_step: next-state and result logic for one item (command or tick)
// depends on lrps_pkg
`default_nettype none

module lrps_step
    import lrps_pkg::*;
(
    input  lrps_cfg_t    cfg,
    input  lrps_item_t   item,
    input  lrps_state_t  state,
    output lrps_state_t  state_next,
    output lrps_result_t result
);

    logic              busy;
    logic              host_cmd;
    logic [TICK_W-1:0] elapsed_inc;
    logic [TICK_W-1:0] step_wait;
    logic              step_done;
    seq_step_t         step_next;
    logic [TICK_W-1:0] elapsed_next;

    logic [NUM_COILS-1:0]  coils;
    logic [TICK_W-1:0]     timer;
    logic                  drv;
    logic                  stop_req;
    logic                  deinit_req;
    logic                  init_req;
    logic                  rep_valid;
    logic [RELAY_W-1:0]    rep_relay;
    logic                  rep_on;
    logic [COIL_NUM_W-1:0] coil_num;
    logic [RELAY_W-1:0]    dual_off;

    assign host_cmd    = (item.op == OP_COMMAND) && (item.relay_index == HOST_RELAY);
    assign elapsed_inc = (state.elapsed == TICK_MAX) ? state.elapsed
                                                     : state.elapsed + 16'd1;
    assign step_done   = (item.op == OP_TICK) && busy && (elapsed_inc >= step_wait);

    // sequence next state
    always_comb
    begin
        busy         = 1'b1;
        step_wait    = cfg.pulse_ticks;
        step_next    = state.step;
        elapsed_next = state.elapsed;
        case (state.step)
            SEQ_ON_PULSE:     step_wait = cfg.pulse_ticks;
            SEQ_SETTLE:       step_wait = cfg.settle_ticks;
            SEQ_AFTER_STOP:   step_wait = cfg.step_ticks;
            SEQ_AFTER_DEINIT: step_wait = cfg.step_ticks;
            SEQ_OFF_PULSE:    step_wait = cfg.pulse_ticks;
            default:          busy = 1'b0;
        endcase
        if (host_cmd && !busy)
        begin
            step_next    = item.turn_on ? SEQ_ON_PULSE : SEQ_AFTER_STOP;
            elapsed_next = '0;
        end
        else if ((item.op == OP_TICK) && busy)
        begin
            elapsed_next = elapsed_inc;
            if (step_done)
            begin
                elapsed_next = '0;
                case (state.step)
                    SEQ_ON_PULSE:     step_next = SEQ_SETTLE;
                    SEQ_AFTER_STOP:   step_next = SEQ_AFTER_DEINIT;
                    SEQ_AFTER_DEINIT: step_next = SEQ_OFF_PULSE;
                    default:          step_next = SEQ_IDLE;
                endcase
            end
        end
    end

    // coil number of a plain relay command
    assign dual_off = item.relay_index - NUM_SINGLE;
    always_comb
    begin
        if (item.relay_index < NUM_SINGLE)
            coil_num = {1'b0, item.relay_index, ~item.turn_on};
        else
            coil_num = DUAL_BASE + COIL_NUM_W'({dual_off[3:0], item.channel, ~item.turn_on});
    end

    // coils, timer, driver and result flags
    always_comb
    begin
        coils      = state.coils;
        timer      = state.pulse_timer;
        drv        = state.driver_on;
        stop_req   = 1'b0;
        deinit_req = 1'b0;
        init_req   = 1'b0;
        rep_valid  = 1'b0;
        rep_relay  = '0;
        rep_on     = 1'b0;
        if (item.op == OP_COMMAND)
        begin
            if (host_cmd)
            begin
                if (!busy)
                begin
                    if (item.turn_on)
                    begin
                        drv                  = 1'b1;
                        coils[HOST_SET_COIL] = 1'b1;
                        timer                = cfg.pulse_ticks;
                    end
                    else
                        stop_req = 1'b1;
                end
            end
            else if (item.relay_index < NUM_RELAYS)
            begin
                drv       = 1'b1;
                coils     = coils | (NUM_COILS'(1) << coil_num);
                timer     = cfg.pulse_ticks;
                rep_valid = 1'b1;
                rep_relay = item.relay_index;
                rep_on    = item.turn_on;
            end
        end
        else
        begin
            if ((state.pulse_timer == '0) || (state.pulse_timer > cfg.pulse_ticks))
            begin
                coils = '0;
                drv   = 1'b0;
                timer = '0;
            end
            else
                timer = state.pulse_timer - 16'd1;
            if (step_done)
            begin
                case (state.step)
                    SEQ_ON_PULSE:
                    begin
                        coils[HOST_SET_COIL] = 1'b0;
                        drv                  = 1'b0;
                    end
                    SEQ_SETTLE:
                    begin
                        init_req  = 1'b1;
                        rep_valid = 1'b1;
                        rep_relay = HOST_RELAY;
                        rep_on    = 1'b1;
                    end
                    SEQ_AFTER_STOP:
                        deinit_req = 1'b1;
                    SEQ_AFTER_DEINIT:
                    begin
                        drv                  = 1'b1;
                        coils[HOST_RST_COIL] = 1'b1;
                        timer                = cfg.pulse_ticks;
                    end
                    default:
                    begin
                        coils[HOST_RST_COIL] = 1'b0;
                        drv                  = 1'b0;
                        rep_valid            = 1'b1;
                        rep_relay            = HOST_RELAY;
                        rep_on               = 1'b0;
                    end
                endcase
            end
        end
    end

    assign state_next.coils       = coils;
    assign state_next.pulse_timer = timer;
    assign state_next.driver_on   = drv;
    assign state_next.step        = step_next;
    assign state_next.elapsed     = elapsed_next;

    assign result.coils_low       = coils[COIL_WORD_W-1:0];
    assign result.coils_high      = coils[NUM_COILS-1:COIL_WORD_W];
    assign result.driver_enable   = drv;
    assign result.host_stop_req   = stop_req;
    assign result.host_deinit_req = deinit_req;
    assign result.host_init_req   = init_req;
    assign result.report_valid    = rep_valid;
    assign result.report_relay    = rep_relay;
    assign result.report_on       = rep_on;
    assign result.sequence_busy   = (step_next != SEQ_IDLE);

endmodule

`default_nettype wire

// File: rtl/latching_relay_pulse_sequencer_unit.sv
// latching relay pulse sequencer, top level: handshakes, registers, state
// depends on lrps_pkg and lrps_step
//
// usage
//  s_* carries items: tuser = op (0 relay command, 1 one tick of time),
//  tdata = relay_index, channel, turn_on. m_* carries one result item per
//  input item: coil words, driver enable, host requests, report, busy flag.
//  cfg_* writes the three tick registers (index 0 pulse, 1 settle, 2 step);
//  it is always ready and an index beyond the list is dropped.
// pipeline and throughput
//  an item sits in the input register and is then worked out and placed in
//  the output register, from which the result is offered. one item per cycle
//  is sustained while m_tready stays high; the relay and sequence state
//  update is a single registered step per item.
// reset
//  all coils off, driver off, timers zero, sequence idle, registers at
//  30, 100 and 10 ticks; both channels empty.
// stall
//  a held result keeps the output register; one more item waits in the input
//  register, after which s_tready drops until m_tready returns.
`default_nettype none

module latching_relay_pulse_sequencer_unit
    import lrps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // relay_index[4:0], channel, turn_on, pad
    input  wire logic                   s_tuser,   // op
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata,   // coils_low[32:0], coils_high[32:0],
                                                   // driver_enable, host_stop_req,
                                                   // host_deinit_req, host_init_req,
                                                   // report_valid, report_relay[4:0],
                                                   // report_on, sequence_busy, pad
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]      cfg_data
);

    lrps_cfg_t    cfg_reg;
    lrps_item_t   item_reg;
    logic         in_valid_reg;
    lrps_state_t  state_reg;
    lrps_state_t  state_next;
    lrps_result_t result_next;
    lrps_result_t result_reg;
    logic         out_valid_reg;
    logic         advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_ticks  <= PULSE_TICKS_RST;
            cfg_reg.settle_ticks <= SETTLE_TICKS_RST;
            cfg_reg.step_ticks   <= STEP_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PULSE_TICKS:  cfg_reg.pulse_ticks  <= cfg_data;
                REG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data;
                REG_STEP_TICKS:   cfg_reg.step_ticks   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op          <= s_tuser;
            item_reg.relay_index <= s_tdata[RELAY_W-1:0];
            item_reg.channel     <= s_tdata[RELAY_W];
            item_reg.turn_on     <= s_tdata[RELAY_W+1];
        end
    end

    lrps_step u_step (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // relay and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.coils       <= '0;
            state_reg.pulse_timer <= '0;
            state_reg.driver_on   <= 1'b0;
            state_reg.step        <= SEQ_IDLE;
            state_reg.elapsed     <= '0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       result_reg.sequence_busy,
                       result_reg.report_on,
                       result_reg.report_relay,
                       result_reg.report_valid,
                       result_reg.host_init_req,
                       result_reg.host_deinit_req,
                       result_reg.host_stop_req,
                       result_reg.driver_enable,
                       result_reg.coils_high,
                       result_reg.coils_low};

endmodule

`default_nettype wire

// File: rtl/lrps_checker.sv
// lrps_checker: port-level checks on the relay pulse sequencer result stream
// depends on lrps_pkg; bound to latching_relay_pulse_sequencer_unit
`default_nettype none

module lrps_checker
    import lrps_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic               rep_valid;
    logic [RELAY_W-1:0] rep_relay;
    logic               rep_on;
    logic               busy;
    logic               stop_req;
    logic               deinit_req;
    logic               init_req;

    assign stop_req   = m_tdata[67];
    assign deinit_req = m_tdata[68];
    assign init_req   = m_tdata[69];
    assign rep_valid  = m_tdata[70];
    assign rep_relay  = m_tdata[75:71];
    assign rep_on     = m_tdata[76];
    assign busy       = m_tdata[77];

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no report means zero relay and state
    a_report_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !rep_valid |-> (rep_relay == '0) && !rep_on)
        else $error("report fields set without report");

    // at most one host request per item
    a_host_req: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({stop_req, deinit_req, init_req}))
        else $error("more than one host request");

    // host relay report ends the sequence, init only with on report
    a_host_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && rep_valid && (rep_relay == HOST_RELAY) |-> !busy)
        else $error("host relay reported while sequence busy");

    a_init_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && init_req |-> rep_valid && rep_on && (rep_relay == HOST_RELAY) && !busy)
        else $error("init request without host relay on report");

endmodule

bind latching_relay_pulse_sequencer_unit lrps_checker u_lrps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/testbench.sv
// testbench for latching_relay_pulse_sequencer_unit: directed table then random phases
// predicts untyped result items from its own copy of coils, timers and sequence state
// depends on lrps_pkg and the block's rtl only
`timescale 1ns / 1ps

module testbench;
    import lrps_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int DIR_N       = 22;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic         typed;
        lrps_item_t   stim;
        lrps_result_t exp;
    } dir_row_t;

    // typed rows follow the reset state with the default pulse length
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{1'b1, '{OP_TICK,    5'd0,  1'b0, 1'b0}, '0},
        '{1'b1, '{OP_COMMAND, 5'd0,  1'b0, 1'b1},
              '{33'h1, 33'h0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 5'd0, 1'b1, 1'b0}},
        '{1'b1, '{OP_COMMAND, 5'd12, 1'b0, 1'b0},
              '{33'h2000001, 33'h0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 5'd12, 1'b0, 1'b0}},
        '{1'b1, '{OP_COMMAND, 5'd22, 1'b1, 1'b1},
              '{33'h2000001, 33'h080000000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 5'd22, 1'b1,
                1'b0}},
        '{1'b1, '{OP_COMMAND, 5'd22, 1'b1, 1'b0},
              '{33'h2000001, 33'h180000000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 5'd22, 1'b0,
                1'b0}},
        '{1'b1, '{OP_COMMAND, 5'd13, 1'b0, 1'b1},
              '{33'h6000001, 33'h180000000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 5'd13, 1'b1,
                1'b0}},
        '{1'b0, '{OP_COMMAND, 5'd31, 1'b1, 1'b1}, '0},
        '{1'b0, '{OP_COMMAND, 5'd23, 1'b0, 1'b0}, '0},
        '{1'b0, '{OP_COMMAND, 5'd5,  1'b1, 1'b1}, '0},
        '{1'b0, '{OP_COMMAND, 5'd16, 1'b1, 1'b1}, '0},
        '{1'b0, '{OP_COMMAND, 5'd17, 1'b0, 1'b0}, '0},
        '{1'b0, '{OP_TICK,    5'd0,  1'b0, 1'b0}, '0},
        '{1'b0, '{OP_COMMAND, 5'd10, 1'b0, 1'b1}, '0},
        '{1'b0, '{OP_COMMAND, 5'd10, 1'b0, 1'b0}, '0},
        '{1'b0, '{OP_COMMAND, 5'd10, 1'b1, 1'b1}, '0},
        '{1'b0, '{OP_COMMAND, 5'd3,  1'b0, 1'b0}, '0},
        '{1'b0, '{OP_TICK,    5'd31, 1'b1, 1'b1}, '0},
        '{1'b0, '{OP_TICK,    5'd0,  1'b0, 1'b0}, '0},
        '{1'b0, '{OP_COMMAND, 5'd21, 1'b1, 1'b0}, '0},
        '{1'b0, '{OP_TICK,    5'd0,  1'b0, 1'b0}, '0},
        '{1'b0, '{OP_COMMAND, 5'd20, 1'b0, 1'b1}, '0},
        '{1'b0, '{OP_COMMAND, 5'd15, 1'b1, 1'b0}, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TICK_W-1:0]      cfg_data;

    // predicted block state
    lrps_cfg_t            tick_regs;
    logic [NUM_COILS-1:0] coil_state;
    logic [TICK_W-1:0]    pulse_left;
    logic [TICK_W-1:0]    elapsed;
    logic                 drive_on;
    seq_step_t            seq_now;

    lrps_result_t expected_results [$];
    lrps_result_t want;
    lrps_result_t got;
    int mismatches;
    int quiet_cycles;
    int send_gap_pct;
    int recv_stall_pct;
    int hold_asked;
    int hold_served;
    int hold_left;

    latching_relay_pulse_sequencer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic lrps_result_t relay_step(input lrps_item_t it);
        lrps_result_t res;
        int           rel;
        int           coil;
        res = '0;
        rel = int'(it.relay_index);
        if (it.op == OP_COMMAND)
        begin
            if (it.relay_index == HOST_RELAY)
            begin
                if (seq_now == SEQ_IDLE)
                begin
                    if (it.turn_on)
                    begin
                        drive_on = 1'b1;
                        coil_state[HOST_SET_COIL] = 1'b1;
                        pulse_left = tick_regs.pulse_ticks;
                        seq_now = SEQ_ON_PULSE;
                    end
                    else
                    begin
                        res.host_stop_req = 1'b1;
                        seq_now = SEQ_AFTER_STOP;
                    end
                    elapsed = '0;
                end
            end
            else if (it.relay_index < NUM_RELAYS)
            begin
                if (it.relay_index < NUM_SINGLE)
                    coil = 2 * rel + (it.turn_on ? 0 : 1);
                else
                    coil = int'(DUAL_BASE) + 4 * (rel - int'(NUM_SINGLE))
                           + 2 * int'(it.channel) + (it.turn_on ? 0 : 1);
                drive_on = 1'b1;
                coil_state[coil] = 1'b1;
                pulse_left = tick_regs.pulse_ticks;
                res.report_valid = 1'b1;
                res.report_relay = it.relay_index;
                res.report_on = it.turn_on;
            end
        end
        else
        begin
            if (pulse_left == '0 || pulse_left > tick_regs.pulse_ticks)
            begin
                coil_state = '0;
                drive_on = 1'b0;
                pulse_left = '0;
            end
            else
                pulse_left = pulse_left - 1'b1;
            if (seq_now != SEQ_IDLE)
            begin
                if (elapsed != TICK_MAX)
                    elapsed = elapsed + 1'b1;
                case (seq_now)
                    SEQ_ON_PULSE:
                        if (elapsed >= tick_regs.pulse_ticks)
                        begin
                            coil_state[HOST_SET_COIL] = 1'b0;
                            drive_on = 1'b0;
                            seq_now = SEQ_SETTLE;
                            elapsed = '0;
                        end
                    SEQ_SETTLE:
                        if (elapsed >= tick_regs.settle_ticks)
                        begin
                            res.host_init_req = 1'b1;
                            res.report_valid = 1'b1;
                            res.report_relay = HOST_RELAY;
                            res.report_on = 1'b1;
                            seq_now = SEQ_IDLE;
                            elapsed = '0;
                        end
                    SEQ_AFTER_STOP:
                        if (elapsed >= tick_regs.step_ticks)
                        begin
                            res.host_deinit_req = 1'b1;
                            seq_now = SEQ_AFTER_DEINIT;
                            elapsed = '0;
                        end
                    SEQ_AFTER_DEINIT:
                        if (elapsed >= tick_regs.step_ticks)
                        begin
                            drive_on = 1'b1;
                            coil_state[HOST_RST_COIL] = 1'b1;
                            pulse_left = tick_regs.pulse_ticks;
                            seq_now = SEQ_OFF_PULSE;
                            elapsed = '0;
                        end
                    default:
                        if (elapsed >= tick_regs.pulse_ticks)
                        begin
                            coil_state[HOST_RST_COIL] = 1'b0;
                            drive_on = 1'b0;
                            res.report_valid = 1'b1;
                            res.report_relay = HOST_RELAY;
                            res.report_on = 1'b0;
                            seq_now = SEQ_IDLE;
                            elapsed = '0;
                        end
                endcase
            end
        end
        res.coils_low = coil_state[COIL_WORD_W-1:0];
        res.coils_high = coil_state[NUM_COILS-1:COIL_WORD_W];
        res.driver_enable = drive_on;
        res.sequence_busy = (seq_now != SEQ_IDLE);
        return res;
    endfunction

    task automatic offer(input lrps_item_t it, input logic typed, input lrps_result_t typed_exp);
        lrps_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, it.turn_on, it.channel, it.relay_index};
        s_tuser <= it.op;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = relay_step(it);
        expected_results.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TICK_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PULSE_TICKS:  tick_regs.pulse_ticks = val;
            REG_SETTLE_TICKS: tick_regs.settle_ticks = val;
            REG_STEP_TICKS:   tick_regs.step_ticks = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly ticks so that pulses and host sequences run to their end
    task automatic run_phase(input int n_items, input int gap_pct, input int stall_pct,
                             input int hold_at, input int pause_at);
        lrps_item_t it;
        int         pick;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == hold_at)
                hold_asked++;
            if (k == pause_at)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            it.op = (pick < 55) ? OP_TICK : OP_COMMAND;
            it.relay_index = RELAY_W'($urandom_range(0, 31));
            if (pick >= 55 && pick < 67)
                it.relay_index = HOST_RELAY;
            else if (pick >= 67 && pick < 93)
                it.relay_index = RELAY_W'($urandom_range(0, 22));
            it.channel = 1'($urandom_range(0, 1));
            it.turn_on = 1'($urandom_range(0, 1));
            offer(it, 1'b0, '0);
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        hold_served = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [COIL_WORD_W-1:0] exp_val,
                               input logic [COIL_WORD_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    got.coils_low       = m_tdata[32:0];
                    got.coils_high      = m_tdata[65:33];
                    got.driver_enable   = m_tdata[66];
                    got.host_stop_req   = m_tdata[67];
                    got.host_deinit_req = m_tdata[68];
                    got.host_init_req   = m_tdata[69];
                    got.report_valid    = m_tdata[70];
                    got.report_relay    = m_tdata[75:71];
                    got.report_on       = m_tdata[76];
                    got.sequence_busy   = m_tdata[77];
                    check_field("coils_low", want.coils_low, got.coils_low);
                    check_field("coils_high", want.coils_high, got.coils_high);
                    check_field("driver_enable", COIL_WORD_W'(want.driver_enable),
                                COIL_WORD_W'(got.driver_enable));
                    check_field("host_stop_req", COIL_WORD_W'(want.host_stop_req),
                                COIL_WORD_W'(got.host_stop_req));
                    check_field("host_deinit_req", COIL_WORD_W'(want.host_deinit_req),
                                COIL_WORD_W'(got.host_deinit_req));
                    check_field("host_init_req", COIL_WORD_W'(want.host_init_req),
                                COIL_WORD_W'(got.host_init_req));
                    check_field("report_valid", COIL_WORD_W'(want.report_valid),
                                COIL_WORD_W'(got.report_valid));
                    check_field("report_relay", COIL_WORD_W'(want.report_relay),
                                COIL_WORD_W'(got.report_relay));
                    check_field("report_on", COIL_WORD_W'(want.report_on),
                                COIL_WORD_W'(got.report_on));
                    check_field("sequence_busy", COIL_WORD_W'(want.sequence_busy),
                                COIL_WORD_W'(got.sequence_busy));
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_COMMAND;
        cfg_valid = 1'b0;
        cfg_index = REG_PULSE_TICKS;
        cfg_data = '0;
        mismatches = 0;
        quiet_cycles = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_asked = 0;
        tick_regs = '{PULSE_TICKS_RST, SETTLE_TICKS_RST, STEP_TICKS_RST};
        coil_state = '0;
        pulse_left = '0;
        elapsed = '0;
        drive_on = 1'b0;
        seq_now = SEQ_IDLE;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_N; i++)
            offer(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].exp);
        run_phase(170, 0, 0, -1, -1);

        // shortest waits
        settle();
        write_reg(REG_PULSE_TICKS, 16'd1);
        write_reg(REG_SETTLE_TICKS, 16'd0);
        write_reg(REG_STEP_TICKS, 16'd0);
        run_phase(200, 50, 0, -1, -1);

        // zero pulse length ends every pulse on the next tick
        settle();
        write_reg(REG_PULSE_TICKS, 16'd0);
        write_reg(REG_SETTLE_TICKS, 16'd3);
        write_reg(REG_STEP_TICKS, 16'd2);
        run_phase(200, 0, 50, -1, -1);

        // longest waits, plus a write to an index that does not exist
        settle();
        write_reg(REG_UNUSED, 16'hffff);
        write_reg(REG_PULSE_TICKS, 16'hffff);
        write_reg(REG_SETTLE_TICKS, 16'hffff);
        write_reg(REG_STEP_TICKS, 16'hffff);
        run_phase(150, 29, 29, -1, -1);

        // timer left above the new pulse length; long receiver hold and a drain pause
        settle();
        write_reg(REG_PULSE_TICKS, 16'd5);
        write_reg(REG_SETTLE_TICKS, 16'd7);
        write_reg(REG_STEP_TICKS, 16'd3);
        run_phase(200, 0, 0, 40, 120);

        settle();
        write_reg(REG_PULSE_TICKS, 16'($urandom_range(1, 40)));
        write_reg(REG_SETTLE_TICKS, 16'($urandom_range(0, 40)));
        write_reg(REG_STEP_TICKS, 16'($urandom_range(0, 40)));
        run_phase(200, 29, 29, -1, -1);

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
